// ===== hdl/bb3_pkg.sv =====
package bb3_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_IMAGE_SIZE  = 1024;
    localparam int DEF_LINE_ADDR_W = 12;

    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int DATA_W     = PIX_W * NUM_CH;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam int SUM_W       = 12;
    localparam int NUM_W       = SUM_W + 1;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic OP_PUSH = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_WAIT,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } t_state;

    // index 0 above or left, 1 centre, 2 below or right
    typedef struct packed {
        logic [2:0] row_vld;
        logic [2:0] col_vld;
    } t_win_mask;

    typedef struct packed {
        logic       shift;
        logic       load;
        logic [1:0] load_row;
        logic       load_col2;
        logic       sum_en;
        logic       mul_en;
    } t_win_ctrl;

    // ceil(2^17 / (2n)) for each neighbour count
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] k;
        case (n)
            4'd1:    k = 17'd65536;
            4'd2:    k = 17'd32768;
            4'd3:    k = 17'd21846;
            4'd4:    k = 17'd16384;
            4'd6:    k = 17'd10923;
            4'd9:    k = 17'd7282;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/bb3_line_mem.sv =====
module bb3_line_mem #(
    parameter int ADDR_W = bb3_pkg::DEF_LINE_ADDR_W
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic                      i_re,
    input  logic [ADDR_W-1:0]         i_addr,
    input  logic [bb3_pkg::DATA_W-1:0] i_wdata,
    output logic [bb3_pkg::DATA_W-1:0] o_rdata
);
    import bb3_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bb3_win_mean.sv =====
module bb3_win_mean (
    input  logic                       i_clk,
    input  bb3_pkg::t_win_ctrl         i_ctrl,
    input  bb3_pkg::t_win_mask         i_mask,
    input  logic [bb3_pkg::DATA_W-1:0] i_rd_data,
    output logic [bb3_pkg::DATA_W-1:0] o_mean
);
    import bb3_pkg::*;

    logic [DATA_W-1:0]  r_win [3][3];
    logic [SUM_W-1:0]   n_sum [NUM_CH];
    logic [SUM_W-1:0]   r_sum [NUM_CH];
    logic [CNT_W-1:0]   n_cnt;
    logic [CNT_W-1:0]   r_cnt;
    logic [1:0]         rows_cnt;
    logic [1:0]         cols_cnt;
    logic [RECIP_W-1:0] recip_k;
    logic [NUM_W-1:0]   num   [NUM_CH];
    logic [PROD_W-1:0]  prod  [NUM_CH];
    logic [PIX_W-1:0]   n_q   [NUM_CH];
    logic [PIX_W-1:0]   r_q   [NUM_CH];

    // window columns: shift left on a step along the row, fill from line memory
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
        end else if (i_ctrl.load) begin
            if (i_ctrl.load_col2) begin
                r_win[i_ctrl.load_row][2] <= i_rd_data;
            end else begin
                r_win[i_ctrl.load_row][1] <= i_rd_data;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_sum[c] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (i_mask.row_vld[i] && i_mask.col_vld[j]) begin
                        n_sum[c] = n_sum[c] + SUM_W'(r_win[i][j][c*PIX_W +: PIX_W]);
                    end
                end
            end
        end
        rows_cnt = 2'(i_mask.row_vld[0]) + 2'(i_mask.row_vld[1]) + 2'(i_mask.row_vld[2]);
        cols_cnt = 2'(i_mask.col_vld[0]) + 2'(i_mask.col_vld[1]) + 2'(i_mask.col_vld[2]);
        n_cnt    = {2'b00, rows_cnt} * {2'b00, cols_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_en) begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

    // rounded mean (2s + n) / 2n by reciprocal multiply
    always_comb begin
        recip_k = recip(r_cnt);
        for (int c = 0; c < NUM_CH; c++) begin
            num[c]  = {r_sum[c], 1'b0} + NUM_W'(r_cnt);
            prod[c] = PROD_W'(num[c]) * PROD_W'(recip_k);
            n_q[c]  = prod[c][RECIP_SHIFT +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_q <= n_q;
        end
    end

    assign o_mean = {r_q[2], r_q[1], r_q[0]};

endmodule

// ===== hdl/box_blur_3x3_clipped_unit.sv =====
// channel  direction  handshake                       payload
// s_axis   in         s_axis_tvalid / s_axis_tready   tdata red, green, blue; tuser operation
// m_axis   out        m_axis_tvalid / m_axis_tready   tdata red, green, blue; tlast frame_end
// cfg      in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// one request in flight; a request that yields no pixel goes back to idle after the check,
// one that does has the single line memory port read 3 neighbours, or 6 at the first pixel
// of a row, one a cycle, then a sum stage and a multiply stage
// reset clears position counters, sets sizes to min(1024, max); line memory is not cleared
// a pixel held in the output register stalls the block only when the next one is finished
module box_blur_3x3_clipped_unit #(
    parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bb3_pkg::DATA_W-1:0]     s_axis_tdata,   // red, green, blue
    input  logic                           s_axis_tuser,   // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bb3_pkg::DATA_W-1:0]     m_axis_tdata,   // red, green, blue
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bb3_pkg::*;

    localparam int CX     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RX     = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W = CW + 2;

    localparam logic [CX-1:0] WIDTH_RST =
        CX'((MAX_WIDTH < DEF_IMAGE_SIZE) ? MAX_WIDTH : DEF_IMAGE_SIZE);
    localparam logic [RX-1:0] HEIGHT_RST =
        RX'((MAX_HEIGHT < DEF_IMAGE_SIZE) ? MAX_HEIGHT : DEF_IMAGE_SIZE);

    localparam logic [2:0] RD_ROWS         = 3'd3;
    localparam logic [2:0] RD_LAST_ONE_COL = 3'd2;
    localparam logic [2:0] RD_LAST_TWO_COL = 3'd5;

    t_state r_state, n_state;

    logic [CX-1:0] r_width,   n_width;
    logic [RX-1:0] r_height,  n_height;
    logic [CX-1:0] r_in_col,  n_in_col;
    logic [RX-1:0] r_in_row,  n_in_row;
    logic [CX-1:0] r_out_col, n_out_col;
    logic [RX-1:0] r_out_row, n_out_row;
    logic [2:0]    r_rd_cnt,  n_rd_cnt;
    logic          r_pend,    n_pend;
    logic [1:0]    r_pend_row, n_pend_row;
    logic          r_pend_col2, n_pend_col2;
    logic          r_m_valid, n_m_valid;
    logic [DATA_W-1:0] r_m_data, n_m_data;
    logic          r_m_last,  n_m_last;

    logic          cfg_wr;
    logic          do_write;
    logic [CX-1:0] in_col_inc;
    logic          in_wrap;
    logic [CX-1:0] out_col_inc;
    logic [RX-1:0] out_row_inc;
    logic [RX-1:0] need_r;
    logic [CX-1:0] need_c;
    logic          px_ready;
    logic          px_last;
    logic          col_zero;
    logic          first_col;
    logic [1:0]    rd_k;
    logic [2:0]    rd_last;
    logic [CX-1:0] rd_col;
    logic [RX+1:0] in_row_x;
    logic [RX+1:0] out_row_x;
    logic [1:0]    in_ring;
    logic [1:0]    out_ring;
    logic [1:0]    rd_ring;
    logic [CX-1:0] width_clamp;
    logic [RX-1:0] height_clamp;
    logic          mem_we;
    logic          mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] mean;
    logic          out_free;
    logic          out_load;
    t_win_ctrl     win_ctrl;
    t_win_mask     win_mask;

    bb3_line_mem #(
        .ADDR_W (ADDR_W)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (s_axis_tdata),
        .o_rdata (mem_rdata)
    );

    bb3_win_mean u_win_mean (
        .i_clk     (i_clk),
        .i_ctrl    (win_ctrl),
        .i_mask    (win_mask),
        .i_rd_data (mem_rdata),
        .o_mean    (mean)
    );

    // position and window bookkeeping
    always_comb begin
        cfg_wr      = i_cfg_valid && o_cfg_ready;
        do_write    = (s_axis_tuser == OP_PUSH) && (r_in_row < r_height);
        in_col_inc  = r_in_col + CX'(1);
        in_wrap     = in_col_inc == r_width;
        out_col_inc = r_out_col + CX'(1);
        out_row_inc = r_out_row + RX'(1);
        need_r      = (out_row_inc < r_height) ? out_row_inc : r_height - RX'(1);
        need_c      = (out_col_inc < r_width) ? out_col_inc : r_width - CX'(1);
        px_ready    = (r_in_row >= r_height) || (r_in_row > need_r) ||
                      ((r_in_row == need_r) && (r_in_col > need_c));
        px_last     = (out_row_inc == r_height) && (out_col_inc == r_width);
        col_zero    = r_out_col == '0;

        win_mask.row_vld = {out_row_inc < r_height, 1'b1, r_out_row != '0};
        win_mask.col_vld = {out_col_inc < r_width, 1'b1, !col_zero};

        first_col = col_zero && (r_rd_cnt < RD_ROWS);
        rd_k      = (r_rd_cnt >= RD_ROWS) ? 2'(r_rd_cnt - RD_ROWS) : 2'(r_rd_cnt);
        rd_last   = col_zero ? RD_LAST_TWO_COL : RD_LAST_ONE_COL;
        rd_col    = first_col ? r_out_col : out_col_inc;

        in_row_x  = {2'b00, r_in_row};
        out_row_x = {2'b00, r_out_row};
        in_ring   = in_row_x[1:0];
        out_ring  = out_row_x[1:0];
        rd_ring   = out_ring + rd_k + 2'd3;

        width_clamp  = (i_cfg_data == '0) ? CX'(1) :
                       (32'(i_cfg_data) > 32'(MAX_WIDTH)) ? CX'(MAX_WIDTH) : CX'(i_cfg_data);
        height_clamp = (i_cfg_data == '0) ? RX'(1) :
                       (32'(i_cfg_data) > 32'(MAX_HEIGHT)) ? RX'(MAX_HEIGHT) : RX'(i_cfg_data);

        out_free = !r_m_valid || m_axis_tready;
        mem_addr = mem_we ? {in_ring, r_in_col[CW-1:0]} : {rd_ring, rd_col[CW-1:0]};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = px_ready ? ST_READ : ST_IDLE;
            end
            ST_READ: begin
                if (r_rd_cnt == rd_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready      = 1'b0;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        out_load           = 1'b0;
        win_ctrl.shift     = 1'b0;
        win_ctrl.load      = r_pend;
        win_ctrl.load_row  = r_pend_row;
        win_ctrl.load_col2 = r_pend_col2;
        win_ctrl.sum_en    = 1'b0;
        win_ctrl.mul_en    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                mem_we        = s_axis_tvalid && do_write;
            end
            ST_CHECK: begin
                win_ctrl.shift = px_ready && !col_zero;
            end
            ST_READ: begin
                mem_re = 1'b1;
            end
            ST_SUM: begin
                win_ctrl.sum_en = 1'b1;
            end
            ST_MUL: begin
                win_ctrl.mul_en = 1'b1;
            end
            ST_OUT: begin
                out_load = out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // register next values
    always_comb begin
        n_rd_cnt    = (r_state == ST_READ) ? 3'(r_rd_cnt + 3'd1) : '0;
        n_pend      = mem_re;
        n_pend_row  = rd_k;
        n_pend_col2 = !first_col;

        n_width   = r_width;
        n_height  = r_height;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_wr) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  n_width  = width_clamp;
                REG_IMAGE_HEIGHT: n_height = height_clamp;
                default:          n_width  = r_width;
            endcase
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (mem_we) begin
            if (in_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + RX'(1);
            end else begin
                n_in_col = in_col_inc;
            end
        end else if (out_load) begin
            if (px_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (out_col_inc == r_width) begin
                n_out_col = '0;
                n_out_row = out_row_inc;
            end else begin
                n_out_col = out_col_inc;
            end
        end

        n_m_valid = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : r_m_valid);
        n_m_data  = out_load ? mean : r_m_data;
        n_m_last  = out_load ? px_last : r_m_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_rd_cnt  <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_width   <= n_width;
            r_height  <= n_height;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_rd_cnt  <= n_rd_cnt;
            r_pend    <= n_pend;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_row  <= n_pend_row;
        r_pend_col2 <= n_pend_col2;
        r_m_data    <= n_m_data;
        r_m_last    <= n_m_last;
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bb3_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    localparam int RING_ROWS     = 4;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam logic OP_DRAIN    = ~OP_PUSH;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        t_rgb mean;
        logic frame_end;
    } t_blurred;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_PUSH;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    t_rgb                  row_ring [RING_ROWS][MAX_W];
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    int                    in_col, in_row, out_col, out_row;
    t_blurred              blur_queue [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    box_blur_3x3_clipped_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: long hold when asked, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic int eff_size(input logic [CFG_DATA_W-1:0] v, input int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return int'(v);
    endfunction

    function automatic logic frame_open();
        return in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0;
    endfunction

    function automatic t_rgb rand_pixel();
        t_rgb p;
        p = DATA_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            p = {3{($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00}};
        return p;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_dim(input int top);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            15:      return CFG_DATA_W'($urandom_range(top + 1, 4 * top));
            default: return CFG_DATA_W'($urandom_range(2, top));
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic rewind_counters();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic predict_blur(input logic op, input t_rgb px);
        int w, h, need_r, need_c, n, r, c;
        int sum_r, sum_g, sum_b;
        t_blurred res;
        w = eff_size(width_reg, MAX_W);
        h = eff_size(height_reg, MAX_H);
        if (op == OP_PUSH && in_row < h && in_col < w) begin
            row_ring[in_row % RING_ROWS][in_col] = px;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (out_row >= h || out_col >= w) return;
        need_r = (out_row + 1 < h) ? out_row + 1 : h - 1;
        need_c = (out_col + 1 < w) ? out_col + 1 : w - 1;
        if (!(in_row >= h || in_row > need_r || (in_row == need_r && in_col > need_c)))
            return;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        n     = 0;
        for (r = out_row - 1; r <= out_row + 1; r++)
            for (c = out_col - 1; c <= out_col + 1; c++)
                if (r >= 0 && r < h && c >= 0 && c < w) begin
                    sum_r += row_ring[r % RING_ROWS][c].red;
                    sum_g += row_ring[r % RING_ROWS][c].green;
                    sum_b += row_ring[r % RING_ROWS][c].blue;
                    n++;
                end
        res.mean.red   = PIX_W'((2 * sum_r + n) / (2 * n));
        res.mean.green = PIX_W'((2 * sum_g + n) / (2 * n));
        res.mean.blue  = PIX_W'((2 * sum_b + n) / (2 * n));
        res.frame_end  = (out_row == h - 1) && (out_col == w - 1);
        blur_queue.push_back(res);
        if (res.frame_end) begin
            rewind_counters();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic send_item(input logic op, input t_rgb px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        predict_blur(op, px);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        rewind_counters();
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        s_axis_tvalid <= 1'b0;
        while (blur_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_run(input int count, input int drain_pct);
        int pushed;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(0, 99) < drain_pct) begin
                send_item(OP_DRAIN, DATA_W'($urandom));
            end else begin
                send_item(OP_PUSH, rand_pixel());
                pushed++;
            end
        end
    endtask

    // pushes past the end of the frame act as drains
    task automatic close_frame();
        while (frame_open())
            send_item(($urandom_range(0, 1) == 0) ? OP_PUSH : OP_DRAIN, DATA_W'($urandom));
    endtask

    task automatic run_frame(input int drain_pct);
        push_run(eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H), drain_pct);
        close_frame();
    endtask

    task automatic test_directed();
        // zero sizes act as one pixel
        set_size(0, 0);
        send_item(OP_PUSH, 24'hFFFFFF);
        send_item(OP_PUSH, 24'h000000);
        // single row: drain with nothing ready, push past the last pixel
        set_size(3, 1);
        send_item(OP_DRAIN, 24'h5AA5C3);
        send_item(OP_PUSH, {8'h80, 8'h00, 8'hFF});
        send_item(OP_PUSH, {8'h01, 8'hFF, 8'h00});
        send_item(OP_PUSH, {8'hFF, 8'hFF, 8'hFF});
        send_item(OP_PUSH, 24'h123456);
        // single column
        set_size(1, 3);
        send_item(OP_PUSH, {8'h00, 8'hFF, 8'h01});
        send_item(OP_PUSH, {8'hFF, 8'h00, 8'h02});
        send_item(OP_PUSH, {8'h7F, 8'h80, 8'h00});
        close_frame();
        // exact halves round up
        set_size(2, 2);
        send_item(OP_PUSH, {8'hFF, 8'h00, 8'h01});
        send_item(OP_PUSH, {8'hFF, 8'h00, 8'h01});
        send_item(OP_PUSH, {8'hFF, 8'h00, 8'h00});
        send_item(OP_PUSH, {8'hFF, 8'h01, 8'h00});
        close_frame();
        // size write part way through a frame
        set_size(3, 3);
        push_run(3, 0);
        set_size(2, 2);
        run_frame(0);
    endtask

    task automatic test_random(input int n_items);
        int   stop_at;
        logic must_resize;
        stop_at     = items_sent + n_items;
        must_resize = 1'b1;
        while (items_sent < stop_at) begin
            if (must_resize || $urandom_range(0, 3) != 0)
                set_size(rand_dim(8), rand_dim(5));
            must_resize = 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                push_run($urandom_range(0, eff_size(width_reg, MAX_W) *
                                           eff_size(height_reg, MAX_H) - 1), 10);
                must_resize = 1'b1;
            end else begin
                run_frame($urandom_range(0, 20));
            end
        end
    endtask

    task automatic test_backpressure();
        set_size(16, 6);
        hold_left = 400;
        run_frame(10);
    endtask

    task automatic test_size_limits();
        // oversized width and height, full width across a row boundary
        set_size(11'h7FF, 11'h7FF);
        push_run(MAX_W + 40, 2);
        set_size(1, 11'h7FF);
        push_run(40, 5);
    endtask

    initial begin
        for (int r = 0; r < RING_ROWS; r++)
            for (int c = 0; c < MAX_W; c++)
                row_ring[r][c] = '0;
        width_reg  = CFG_DATA_W'(DEF_IMAGE_SIZE);
        height_reg = CFG_DATA_W'(DEF_IMAGE_SIZE);
        rewind_counters();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 14;
        recv_idle_pct = 70;
        test_directed();
        test_random(225);
        test_backpressure();

        send_idle_pct = 70;
        recv_idle_pct = 14;
        test_random(225);
        test_size_limits();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(225);

        s_axis_tvalid <= 1'b0;
        while (blur_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && blur_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin : check_output
        t_blurred want;
        t_rgb     got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (blur_queue.size() == 0) begin
                $display("%0t: unexpected pixel expected none actual %h tlast %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = blur_queue.pop_front();
                check_field("red", want.mean.red, got.red);
                check_field("green", want.mean.green, got.green);
                check_field("blue", want.mean.blue, got.blue);
                check_field("tlast", 8'(want.frame_end), 8'(m_axis_tlast));
            end
        end
    end

endmodule
